@@ rtl/shs_pkg.sv @@
package shs_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] hvec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } shs_state_e;

  typedef struct packed {
    logic  push;
    logic  shift;
    word_t push_word;
  } sched_ctrl_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  localparam hvec_t InitH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 hasher that takes a message, at most one byte per request, and
// returns the eight digest words, word 0 first, after the request marked
// end_of_message. The 64th byte of a block starts a shared round unit that
// runs 64 rounds at one per cycle and then folds the result into the chain
// value. Padding is fed one byte per cycle through the same path, plus
// a second block when fewer than nine bytes were free, and then eight
// output requests.
// The block does not take input while it compresses, pads or shows the digest.
module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o,
  output logic        too_long_o
);
  import shs_pkg::*;

  shs_state_e  state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [60:0] cnt_q, cnt_d;
  logic        ovf_q, ovf_d;
  logic        in_pad_q, in_pad_d;
  logic        pad_first_q, pad_first_d;
  logic        final_blk_q, final_blk_d;
  logic        last_blk_q, last_blk_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  word_q, word_d;
  hvec_t       h_q, h_d;
  hvec_t       v_q, v_d;
  logic [23:0] cur_q, cur_d;

  logic        in_fire;
  logic        out_fire;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        blk_done;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [63:0] bits;
  logic [2:0]  len_idx;
  logic        sat;
  sched_ctrl_t sched_ctrl;
  word_t       w0;
  hvec_t       v_next;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign sat      = &cnt_q;
  assign bits     = {cnt_q, 3'b000};
  assign len_idx  = 3'(3'd7 - pos_q[2:0]);
  assign len_byte = bits[{len_idx, 3'b000} +: 8];
  assign pad_byte = pad_first_q ? PadByte :
                    ((final_blk_q && (pos_q >= LenPos)) ? len_byte : 8'h00);
  assign blk_done = wr_en && (pos_q == 6'd63);

  assign sched_ctrl.push      = wr_en && (pos_q[1:0] == 2'b11);
  assign sched_ctrl.shift     = (state_q == ST_ROUND);
  assign sched_ctrl.push_word = {cur_q, wr_byte};

  shs_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w0_o   (w0)
  );

  shs_round u_round (
    .v_i (v_q),
    .k_i (RoundK[rnd_q]),
    .w_i (w0),
    .v_o (v_next)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (blk_done) begin
            state_d = ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pos_q == 6'd63) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!in_pad_q) begin
          state_d = ST_IDLE;
        end else if (last_blk_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_fire && (word_q == 3'd7)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    wr_en       = 1'b0;
    wr_byte     = data_byte_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        wr_en      = in_valid_i && has_byte_i && !sat;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = pad_byte;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    in_pad_d    = in_pad_q;
    pad_first_d = pad_first_q;
    final_blk_d = final_blk_q;
    last_blk_d  = last_blk_q;
    rnd_d       = rnd_q;
    word_d      = word_q;
    h_d         = h_q;
    v_d         = v_q;
    cur_d       = cur_q;

    if (wr_en) begin
      pos_d = pos_q + 6'd1;
      cur_d = {cur_q[15:0], wr_byte};
    end
    if (blk_done) begin
      v_d   = h_q;
      rnd_d = 6'd0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (has_byte_i) begin
            if (sat) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d = cnt_q + 61'd1;
            end
          end
          last_blk_d = 1'b0;
          if (end_of_message_i) begin
            in_pad_d    = 1'b1;
            pad_first_d = 1'b1;
            final_blk_d = (pos_d < LenPos);
          end
        end
      end
      ST_PAD: begin
        pad_first_d = 1'b0;
        if (pos_q == 6'd63) begin
          last_blk_d  = final_blk_q;
          final_blk_d = 1'b1;
        end
      end
      ST_ROUND: begin
        v_d   = v_next;
        rnd_d = rnd_q + 6'd1;
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        word_d = 3'd0;
      end
      ST_OUT: begin
        if (out_fire) begin
          word_d = word_q + 3'd1;
          if (word_q == 3'd7) begin
            h_d      = InitH;
            cnt_d    = 61'd0;
            ovf_d    = 1'b0;
            in_pad_d = 1'b0;
            pos_d    = 6'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= 6'd0;
      cnt_q       <= 61'd0;
      ovf_q       <= 1'b0;
      in_pad_q    <= 1'b0;
      pad_first_q <= 1'b0;
      final_blk_q <= 1'b0;
      last_blk_q  <= 1'b0;
      rnd_q       <= 6'd0;
      word_q      <= 3'd0;
      h_q         <= InitH;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      in_pad_q    <= in_pad_d;
      pad_first_q <= pad_first_d;
      final_blk_q <= final_blk_d;
      last_blk_q  <= last_blk_d;
      rnd_q       <= rnd_d;
      word_q      <= word_d;
      h_q         <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    cur_q <= cur_d;
  end

  assign digest_word_o = h_q[word_q];
  assign word_number_o = word_q;
  assign last_word_o   = (word_q == 3'd7);
  assign too_long_o    = ovf_q;

endmodule

@@ rtl/shs_sched.sv @@
module shs_sched (
  input  logic                clk_i,
  input  shs_pkg::sched_ctrl_t ctrl_i,
  output shs_pkg::word_t      w0_o
);
  import shs_pkg::*;

  word_t win_q [16];
  word_t expand;
  word_t sig0;
  word_t sig1;
  word_t new_word;

  always_comb begin
    sig0 = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
    sig1 = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
    expand = sig1 + win_q[9] + sig0 + win_q[0];
    new_word = ctrl_i.push ? ctrl_i.push_word : expand;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push || ctrl_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[15] <= new_word;
    end
  end

  assign w0_o = win_q[0];

endmodule

@@ rtl/shs_round.sv @@
module shs_round (
  input  shs_pkg::hvec_t v_i,
  input  shs_pkg::word_t k_i,
  input  shs_pkg::word_t w_i,
  output shs_pkg::hvec_t v_o
);
  import shs_pkg::*;

  word_t s0;
  word_t s1;
  word_t ch;
  word_t mj;
  word_t t1;

  always_comb begin
    s1 = ror(v_i[4], 6) ^ ror(v_i[4], 11) ^ ror(v_i[4], 25);
    ch = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1 = v_i[7] + s1 + ch + k_i + w_i;
    s0 = ror(v_i[0], 2) ^ ror(v_i[0], 13) ^ ror(v_i[0], 22);
    mj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    v_o[0] = t1 + s0 + mj;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];
  end

endmodule

@@ rtl/shs_checker.sv @@
module shs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_number_o,
  input logic        last_word_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while a digest is shown.");

  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_number_o == 3'd0))
    else $error("Digest does not start at word zero.");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (!out_valid_o && in_ready_o))
    else $error("Digest does not end after the last word.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(digest_word_o)))
    else $error("Stalled digest word changed.");

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .digest_word_o (digest_word_o),
  .word_number_o (word_number_o),
  .last_word_o   (last_word_o)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import shs_pkg::word_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] number;
    logic       last;
    logic       too_long;
  } digest_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
    logic       known;
    word_t      known_w0;
  } request_row_t;

  localparam int NumDirected = 13;
  localparam int RandomRequests = 260;
  localparam logic [7:0] FillByte = 8'h80;
  localparam int LengthPos = 56;
  localparam word_t EmptyDigestW0 = 32'he3b0c442;

  localparam request_row_t DirectedRows [NumDirected] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigestW0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'ha5, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'hfe, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigestW0},
    '{8'h55, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'haa, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  localparam int EdgeLengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  localparam word_t ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t ShaH0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_number_o;
  logic        last_word_o;
  logic        too_long_o;

  word_t        hash_state [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  bytes_taken;
  logic         count_saturated;
  digest_word_t pending_words [$];
  digest_word_t head_word;
  int           errors = 0;

  sha256_stream_hasher_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_number_o    (word_number_o),
    .last_word_o      (last_word_o),
    .too_long_o       (too_long_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, ch, mj, t1;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {msg_block[4 * i], msg_block[4 * i + 1], msg_block[4 * i + 2],
                  msg_block[4 * i + 3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(sched[i - 15], 7) ^ rotr(sched[i - 15], 18) ^ (sched[i - 15] >> 3);
      s1 = rotr(sched[i - 2], 17) ^ rotr(sched[i - 2], 19) ^ (sched[i - 2] >> 10);
      sched[i] = sched[i - 16] + s0 + sched[i - 7] + s1;
    end
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + ShaK[i] + sched[i];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + s0 + mj;
    end
    for (int i = 0; i < 8; i++) begin
      hash_state[i] = hash_state[i] + v[i];
    end
  endfunction

  function automatic void restart_message();
    hash_state = ShaH0;
    bytes_taken = '0;
    count_saturated = 1'b0;
  endfunction

  function automatic void absorb_request(logic [7:0] data, logic has, logic eom);
    int         pos;
    logic [63:0] bit_len;
    digest_word_t item;
    if (has) begin
      if (&bytes_taken) begin
        count_saturated = 1'b1;
      end else begin
        msg_block[bytes_taken[5:0]] = data;
        bytes_taken = bytes_taken + 61'd1;
        if (bytes_taken[5:0] == 6'd0) begin
          compress_block();
        end
      end
    end
    if (eom) begin
      pos = int'(bytes_taken[5:0]);
      msg_block[pos] = FillByte;
      for (int i = pos + 1; i < 64; i++) begin
        msg_block[i] = 8'h00;
      end
      if (pos >= LengthPos) begin
        compress_block();
        for (int i = 0; i < 64; i++) begin
          msg_block[i] = 8'h00;
        end
      end
      bit_len = {bytes_taken, 3'b000};
      for (int i = 0; i < 8; i++) begin
        msg_block[LengthPos + i] = bit_len[8 * (7 - i) +: 8];
      end
      compress_block();
      for (int i = 0; i < 8; i++) begin
        item.word = hash_state[i];
        item.number = 3'(i);
        item.last = (i == 7);
        item.too_long = count_saturated;
        pending_words.push_back(item);
      end
      restart_message();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 8);
    if (r < 8) return EdgeLengths[$urandom_range(0, 7)];
    if (r < 9) return $urandom_range(110, 130);
    return $urandom_range(0, 64);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s, got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic issue_request(logic [7:0] data, logic has, logic eom);
    in_valid_i <= 1'b1;
    data_byte_i <= data;
    has_byte_i <= has;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_request(data, has, eom);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_digests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected digest word", digest_word_o, 32'h0);
      end else begin
        head_word = pending_words.pop_front();
        if (digest_word_o !== head_word.word)
          report_mismatch("digest_word", digest_word_o, head_word.word);
        if (word_number_o !== head_word.number)
          report_mismatch("word_number", 32'(word_number_o), 32'(head_word.number));
        if (last_word_o !== head_word.last)
          report_mismatch("last_word", 32'(last_word_o), 32'(head_word.last));
        if (too_long_o !== head_word.too_long)
          report_mismatch("too_long", 32'(too_long_o), 32'(head_word.too_long));
      end
    end
  end

  initial begin
    int run;
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int  counted;
    int  msg_len;
    int  tail_byte;
    int  messages;
    bit  steady;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    has_byte_i = 1'b0;
    end_of_message_i = 1'b0;
    for (int i = 0; i < 64; i++) begin
      msg_block[i] = 8'h00;
    end
    restart_message();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      issue_request(DirectedRows[r].data, DirectedRows[r].has_byte, DirectedRows[r].eom);
      if (DirectedRows[r].known) begin
        pending_words[pending_words.size() - 8].word = DirectedRows[r].known_w0;
      end
      pause_sender(pick_gap());
    end

    counted = 0;
    messages = 0;
    while (counted < RandomRequests) begin
      if (messages == 0 || $urandom_range(0, 4) == 0) begin
        drain_digests();
      end
      steady = ($urandom_range(0, 3) == 0);
      msg_len = pick_length();
      tail_byte = (msg_len > 0) ? int'($urandom_range(0, 1)) : 0;
      for (int n = 0; n < msg_len - tail_byte; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          issue_request(8'($urandom), 1'b0, 1'b0);
        end
        issue_request(8'($urandom), 1'b1, 1'b0);
        counted++;
        if (!steady) pause_sender(pick_gap());
      end
      issue_request(8'($urandom), tail_byte[0], 1'b1);
      counted++;
      if (!steady) pause_sender(pick_gap());
      messages++;
    end

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/shs_pkg.sv
rtl/shs_sched.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher_unit.sv
rtl/shs_checker.sv
tb/testbench.sv
